// ===== hdl/cme_pkg.sv =====
package cme_pkg;

  typedef struct packed {
    logic        kind;
    logic [7:0]  fmt_byte;
    logic [11:0] dest_col;
    logic [11:0] dest_line;
  } in_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       format_error;
  } out_rsp_t;

  localparam logic KIND_START = 1'b0;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_GT      = 8'h3E;
  localparam logic [7:0] CH_TWO     = 8'h32;
  localparam logic [7:0] CH_THREE   = 8'h33;
  localparam logic [7:0] CH_DEC     = 8'h64;
  localparam logic [7:0] CH_REV     = 8'h72;
  localparam logic [7:0] CH_INC     = 8'h69;
  localparam logic [7:0] CH_XOR     = 8'h6E;
  localparam logic [7:0] CH_BCD     = 8'h42;
  localparam logic [7:0] CH_DELTA   = 8'h44;

  localparam logic [15:0] XOR_MASK   = 16'h0060;
  localparam logic [7:0]  DIGIT_BASE = 8'h30;

  // reciprocals: v/10 = (v*52429)>>19, v/100 = (v*83887)>>23, r/10 = (r*205)>>11
  localparam logic [16:0] RECIP_10  = 17'd52429;
  localparam logic [16:0] RECIP_100 = 17'd83887;
  localparam logic [7:0]  RECIP_10S = 8'd205;

  typedef enum logic [5:0] {
    PH_NORMAL = 6'b000001,
    PH_ESC    = 6'b000010,
    PH_PLUS   = 6'b000100,
    PH_GT_CMP = 6'b001000,
    PH_GT_ADD = 6'b010000,
    PH_DONE   = 6'b100000
  } phase_e;

  typedef enum logic [2:0] {
    OP_LIT  = 3'd0,
    OP_ERR  = 3'd1,
    OP_DEC  = 3'd2,
    OP_DIG2 = 3'd3,
    OP_DIG3 = 3'd4
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [7:0]  lit_byte;
    logic [15:0] value;
  } cmd_t;

  localparam int unsigned QDEPTH = 2;

endpackage

// ===== hdl/cme_front.sv =====
module cme_front import cme_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  in_req_t in_req_i,
  input  logic    q_full_i,
  output logic    push_o,
  output cmd_t    push_cmd_o
);

  phase_e      phase_q, phase_d;
  logic [15:0] cur_q, cur_d;
  logic        oncol_q, oncol_d;
  logic [15:0] col_q, col_d;
  logic [15:0] line_q, line_d;
  logic [7:0]  cmp_q, cmp_d;

  logic        acc;
  logic [7:0]  b;
  logic [32:0] div_prod;
  logic [12:0] q10;
  logic [15:0] rem16;
  logic [15:0] bcd_val;
  logic [15:0] other_val;

  assign in_stall_o = q_full_i;
  assign acc        = in_valid_i & ~q_full_i;
  assign b          = in_req_i.fmt_byte;

  assign div_prod  = {17'b0, cur_q} * {16'b0, RECIP_10};
  assign q10       = div_prod[31:19];
  assign rem16     = cur_q - {3'b0, q10} * 16'd10;
  assign bcd_val   = {q10[11:0], 4'b0} + {12'b0, rem16[3:0]};
  // value selected after a toggle
  assign other_val = oncol_q ? line_q : col_q;

  always_comb begin
    phase_d    = phase_q;
    cur_d      = cur_q;
    oncol_d    = oncol_q;
    col_d      = col_q;
    line_d     = line_q;
    cmp_d      = cmp_q;
    push_o     = 1'b0;
    push_cmd_o = '{op: OP_LIT, lit_byte: b, value: cur_q};
    if (acc) begin
      if (in_req_i.kind == KIND_START) begin
        col_d   = {4'b0, in_req_i.dest_col};
        line_d  = {4'b0, in_req_i.dest_line};
        cur_d   = {4'b0, in_req_i.dest_line};
        oncol_d = 1'b0;
        phase_d = PH_NORMAL;
        cmp_d   = '0;
      end else begin
        case (phase_q)
          PH_NORMAL: begin
            if (b == CH_NUL) begin
              phase_d = PH_DONE;
            end else if (b == CH_PERCENT) begin
              phase_d = PH_ESC;
            end else begin
              push_o = 1'b1;
            end
          end
          PH_ESC: begin
            phase_d = PH_NORMAL;
            case (b)
              CH_DEC, CH_TWO, CH_THREE: begin
                push_o = 1'b1;
                push_cmd_o.op = (b == CH_DEC) ? OP_DEC : (b == CH_TWO) ? OP_DIG2 : OP_DIG3;
                oncol_d = ~oncol_q;
                cur_d   = other_val;
              end
              CH_PLUS:    phase_d = PH_PLUS;
              CH_GT:      phase_d = PH_GT_CMP;
              CH_REV: begin
                oncol_d = 1'b1;
                cur_d   = col_q;
              end
              CH_INC: begin
                col_d  = col_q + 16'd1;
                line_d = line_q + 16'd1;
                cur_d  = cur_q + 16'd1;
              end
              CH_XOR: begin
                col_d  = col_q ^ XOR_MASK;
                line_d = line_q ^ XOR_MASK;
                cur_d  = (oncol_q ? col_q : line_q) ^ XOR_MASK;
              end
              CH_BCD:   cur_d = bcd_val;
              CH_DELTA: cur_d = cur_q - {11'b0, cur_q[3:0], 1'b0};
              CH_PERCENT: begin
                push_o = 1'b1;
                push_cmd_o.lit_byte = CH_PERCENT;
              end
              default: begin
                push_o = 1'b1;
                push_cmd_o.op = OP_ERR;
                phase_d = PH_DONE;
              end
            endcase
          end
          PH_PLUS: begin
            push_o = 1'b1;
            push_cmd_o.lit_byte = cur_q[7:0] + b;
            oncol_d = ~oncol_q;
            cur_d   = other_val;
            phase_d = PH_NORMAL;
          end
          PH_GT_CMP: begin
            cmp_d   = b;
            phase_d = PH_GT_ADD;
          end
          PH_GT_ADD: begin
            if (cur_q > {8'b0, cmp_q}) begin
              cur_d = cur_q + {8'b0, b};
            end
            phase_d = PH_NORMAL;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_NORMAL;
      cur_q   <= '0;
      oncol_q <= 1'b0;
      col_q   <= '0;
      line_q  <= '0;
      cmp_q   <= '0;
    end else begin
      phase_q <= phase_d;
      cur_q   <= cur_d;
      oncol_q <= oncol_d;
      col_q   <= col_d;
      line_q  <= line_d;
      cmp_q   <= cmp_d;
    end
  end

endmodule

// ===== hdl/cme_queue.sv =====
module cme_queue import cme_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  output logic valid_o,
  output cmd_t cmd_o,
  input  logic pop_i
);

  localparam int unsigned PtrW = $clog2(QDEPTH);
  localparam int unsigned CntW = $clog2(QDEPTH + 1);

  cmd_t            mem_q [QDEPTH];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(QDEPTH - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(QDEPTH - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// ===== hdl/cme_back.sv =====
module cme_back import cme_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     q_valid_i,
  input  cmd_t     q_cmd_i,
  output logic     q_pop_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_rsp_t out_rsp_o
);

  // stage 1: hundreds quotient
  logic        s1_valid_q;
  cmd_t        s1_cmd_q;
  logic [9:0]  s1_q100_q;
  logic [32:0] q100_prod;

  // stage 2: emitter
  logic        s2_valid_q;
  logic [7:0]  s2_b0_q, s2_b1_q, s2_b2_q;
  logic [1:0]  s2_cnt_q, s2_idx_q;
  logic        s2_err_q;

  logic        out_fire, s2_last, s2_free, s1_move, s1_free;
  logic [15:0] r16;
  logic [6:0]  r;
  logic [14:0] t_prod;
  logic [3:0]  tens, ones;
  logic [7:0]  q10_lo;
  logic [7:0]  hun_b, ten_b, one_b, two_b;
  logic [7:0]  b0_d, b1_d, b2_d;
  logic [1:0]  cnt_d;
  logic        err_d;

  assign q100_prod = {17'b0, q_cmd_i.value} * {16'b0, RECIP_100};

  assign out_fire = s2_valid_q & ~out_stall_i;
  assign s2_last  = (s2_idx_q == s2_cnt_q);
  assign s2_free  = ~s2_valid_q | (out_fire & s2_last);
  assign s1_move  = s1_valid_q & s2_free;
  assign s1_free  = ~s1_valid_q | s1_move;
  assign q_pop_o  = q_valid_i & s1_free;

  assign r16    = s1_cmd_q.value - {6'b0, s1_q100_q} * 16'd100;
  assign r      = r16[6:0];
  assign t_prod = {8'b0, r} * {7'b0, RECIP_10S};
  assign tens   = t_prod[14:11];
  assign ones   = 4'(r - {3'b0, tens} * 7'd10);
  assign q10_lo = 8'(s1_q100_q * 10'd10) + {4'b0, tens};
  assign hun_b  = s1_q100_q[7:0] | DIGIT_BASE;
  assign ten_b  = DIGIT_BASE | {4'b0, tens};
  assign one_b  = DIGIT_BASE | {4'b0, ones};
  assign two_b  = q10_lo | DIGIT_BASE;

  always_comb begin
    b0_d  = s1_cmd_q.lit_byte;
    b1_d  = one_b;
    b2_d  = one_b;
    cnt_d = 2'd0;
    err_d = 1'b0;
    case (s1_cmd_q.op)
      OP_LIT: ;
      OP_ERR: begin
        b0_d  = '0;
        err_d = 1'b1;
      end
      OP_DIG2: begin
        b0_d  = two_b;
        cnt_d = 2'd1;
      end
      OP_DIG3: begin
        b0_d  = hun_b;
        b1_d  = ten_b;
        cnt_d = 2'd2;
      end
      OP_DEC: begin
        if (s1_q100_q != '0) begin
          b0_d  = hun_b;
          b1_d  = ten_b;
          cnt_d = 2'd2;
        end else if (tens != '0) begin
          b0_d  = ten_b;
          cnt_d = 2'd1;
        end else begin
          b0_d  = one_b;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      s1_cmd_q  <= q_cmd_i;
      s1_q100_q <= q100_prod[32:23];
    end
    if (s1_move) begin
      s2_b0_q  <= b0_d;
      s2_b1_q  <= b1_d;
      s2_b2_q  <= b2_d;
      s2_cnt_q <= cnt_d;
      s2_err_q <= err_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s2_idx_q   <= '0;
    end else begin
      if (q_pop_o) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        s2_valid_q <= 1'b1;
        s2_idx_q   <= '0;
      end else if (out_fire) begin
        if (s2_last) begin
          s2_valid_q <= 1'b0;
        end else begin
          s2_idx_q <= s2_idx_q + 2'd1;
        end
      end
    end
  end

  always_comb begin
    case (s2_idx_q)
      2'd0:    out_rsp_o.out_byte = s2_b0_q;
      2'd1:    out_rsp_o.out_byte = s2_b1_q;
      default: out_rsp_o.out_byte = s2_b2_q;
    endcase
    out_rsp_o.last_of_run  = s2_last;
    out_rsp_o.format_error = s2_err_q;
  end

  assign out_valid_o = s2_valid_q;

endmodule

// ===== hdl/cursor_motion_format_expander.sv =====
// Termcap cursor-motion expander. Send a start request with column and line,
// then the format string one byte per request. Requests are taken one per
// cycle while the 2-entry command queue has room; a format byte that yields
// output adds one command. The output side sends one byte per cycle while
// out_stall_i is low, so %d, %2 and %3 hold it for up to three bytes, the
// queue fills behind them and the input stalls. The first output byte is
// registered in the queue, quotient stage and emitter in turn. last_of_run
// marks a request's final byte; an unknown escape gives one byte 0 with
// format_error set and input is then dropped until the next start request.
module cursor_motion_format_expander import cme_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_rsp_t out_rsp_o
);

  logic push, q_full, q_valid, q_pop;
  cmd_t push_cmd, q_cmd;

  cme_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .push_cmd_o (push_cmd)
  );

  cme_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .valid_o    (q_valid),
    .cmd_o      (q_cmd),
    .pop_i      (q_pop)
  );

  cme_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_cmd_i     (q_cmd),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule
